@@ rtl/core/ucc_pkg.sv @@
// Shared types, codes and constants for the UPS power and charge controller.
package ucc_pkg;

  localparam int unsigned HOLD_MAX_TICKS_DEF = 60000;

  localparam int TICK_W = 16;
  localparam logic [TICK_W-1:0] HOLD_1S  = 16'd1000;
  localparam logic [TICK_W-1:0] HOLD_2S  = 16'd2000;
  localparam logic [TICK_W-1:0] HOLD_4S  = 16'd4000;
  localparam logic [TICK_W-1:0] HOLD_10S = 16'd10000;

  localparam logic signed [7:0] CAP_FULL = 8'sd100;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_ONLINE_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BATT_LOW_LEVEL      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BATT_EMPTY_LEVEL    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_PWM_SETPOINT = 2'd3;

  localparam logic [9:0] ONLINE_THRESHOLD_RST = 10'd700;
  localparam logic [6:0] BATT_LOW_RST         = 7'd20;
  localparam logic [6:0] BATT_EMPTY_RST       = 7'd5;
  localparam logic [7:0] PWM_SETPOINT_RST     = 8'd0;

  typedef enum logic [1:0] {
    PWR_STARTUP  = 2'd0,
    PWR_ON       = 2'd1,
    PWR_STBY_CHG = 2'd2,
    PWR_STBY     = 2'd3
  } pwr_state_t;

  typedef enum logic [2:0] {
    BAT_INIT        = 3'd0,
    BAT_CHARGED     = 3'd1,
    BAT_CHARGING    = 3'd2,
    BAT_DISCHARGING = 3'd3,
    BAT_LOW         = 3'd4,
    BAT_EMPTY       = 3'd5
  } bat_mode_t;

  typedef enum logic [2:0] {
    LVL_RELEASED = 3'd0,
    LVL_PRESSED  = 3'd1,
    LVL_1S       = 3'd2,
    LVL_2S       = 3'd3,
    LVL_4S       = 3'd4,
    LVL_10S      = 3'd5
  } hold_lvl_t;

  // Button hold actions, at most one per tick
  typedef struct packed {
    logic toggle;
    logic off;
    logic restart;
  } btn_evt_t;

  typedef struct packed {
    logic out19;
    logic dc19_dis;
    logic chg;
    logic dischg;
  } sw_t;

  localparam sw_t SW_RST = '{out19: 1'b0, dc19_dis: 1'b1, chg: 1'b0, dischg: 1'b1};

endpackage

@@ rtl/core/ucc_button.sv @@
// Button hold timer: counts held ticks, tracks hold level, raises hold actions.
module ucc_button
  import ucc_pkg::*;
#(
  parameter int unsigned HOLD_MAX_TICKS = HOLD_MAX_TICKS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  logic      held,
  output hold_lvl_t level_next,
  output btn_evt_t  evt
);

  localparam logic [TICK_W-1:0] HoldMax = TICK_W'(HOLD_MAX_TICKS);

  logic [TICK_W-1:0] press_ticks, press_ticks_next;
  hold_lvl_t         hold_level;

  always_comb begin
    hold_lvl_t lvl;
    logic [TICK_W-1:0] t;
    lvl = hold_level;
    t   = press_ticks;
    evt = '0;
    if (!held) begin
      t   = '0;
      lvl = LVL_RELEASED;
    end else begin
      if (press_ticks < HoldMax) t = press_ticks + 1'b1;
      if (lvl < LVL_PRESSED) lvl = LVL_PRESSED;
      if (t >= HOLD_1S && t < HOLD_2S) lvl = LVL_1S;
      if (t >= HOLD_2S && t < HOLD_4S) begin
        if (lvl < LVL_2S) evt.toggle = 1'b1;
        lvl = LVL_2S;
      end
      if (t >= HOLD_4S && t < HOLD_10S) begin
        if (lvl < LVL_4S) evt.off = 1'b1;
        lvl = LVL_4S;
      end
      if (t >= HOLD_10S && t < HoldMax) begin
        if (lvl < LVL_10S) evt.restart = 1'b1;
        lvl = LVL_10S;
      end
    end
    press_ticks_next = t;
    level_next       = lvl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_ticks <= '0;
      hold_level  <= LVL_RELEASED;
    end else if (adv) begin
      press_ticks <= press_ticks_next;
      hold_level  <= level_next;
    end
  end

  a_ticks_bound: assert property (@(posedge clk) disable iff (rst)
    press_ticks <= HoldMax)
    else $error("press counter past saturation");
  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    adv && !held |=> press_ticks == '0 && hold_level == LVL_RELEASED)
    else $error("release did not clear hold timer");
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0(evt))
    else $error("more than one hold action in a tick");

endmodule

@@ rtl/core/ucc_power.sv @@
// Power state, charge state machine and switch levels, updated once per tick.
module ucc_power
  import ucc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  btn_evt_t          evt,
  input  logic [9:0]        vcode,
  input  logic signed [15:0] cur_ma,
  input  logic signed [7:0] cap,
  input  logic              slow,
  input  logic [9:0]        online_thr,
  input  logic [6:0]        low_lvl,
  input  logic [6:0]        empty_lvl,
  input  logic [7:0]        pwm_setpoint,
  output pwr_state_t        pwr_next,
  output bat_mode_t         bat_next,
  output sw_t               sw_next,
  output logic              online,
  output logic              pwm_wr,
  output logic [7:0]        pwm_val
);

  pwr_state_t pwr_state;
  bat_mode_t  bat_mode;
  sw_t        sw;
  logic       online_prev;

  logic signed [8:0] cap_x, low_x, empty_x;
  logic              cur_le0;

  assign cap_x   = {cap[7], cap};
  assign low_x   = {2'b00, low_lvl};
  assign empty_x = {2'b00, empty_lvl};
  // current reads as zero after an offline tick
  assign cur_le0 = !online_prev || cur_ma[15] || (cur_ma == '0);
  assign online  = vcode > online_thr;

  always_comb begin
    pwr_state_t ps;
    bat_mode_t  bm;
    sw_t        s;
    logic       wr;
    ps = pwr_state;
    bm = bat_mode;
    s  = sw;
    wr = 1'b0;

    if (evt.toggle) begin
      if (ps == PWR_STBY_CHG || ps == PWR_STBY) begin
        ps = PWR_ON;    s.out19 = 1'b1; s.dc19_dis = 1'b0; s.dischg = 1'b1;
      end else begin
        ps = PWR_STBY;  s.out19 = 1'b0; s.dc19_dis = 1'b1; s.dischg = 1'b1;
      end
    end
    if (evt.off) begin
      s.out19 = 1'b0; s.dc19_dis = 1'b1; s.chg = 1'b0; s.dischg = 1'b0;
    end
    if (evt.restart) begin
      ps = PWR_STBY; s.out19 = 1'b0; s.dc19_dis = 1'b1; s.dischg = 1'b1;
    end

    if (online) begin
      if (bm != BAT_CHARGED) begin
        wr = 1'b1; s.chg = 1'b1; bm = BAT_CHARGING;
        if (ps == PWR_STBY) ps = PWR_STBY_CHG;
      end
      if (bm == BAT_CHARGING && cap == CAP_FULL && cur_le0) begin
        wr = 1'b1; s.chg = 1'b0; bm = BAT_CHARGED;
        if (ps == PWR_STBY_CHG) ps = PWR_STBY;
      end
    end else begin
      if (cap_x > low_x) bm = BAT_DISCHARGING;
      if (cap_x < low_x && cap_x > empty_x) bm = BAT_LOW;
      if (cap_x < empty_x) bm = BAT_EMPTY;
    end

    if (slow && !(cap_x > 9'sd0)) begin
      if (ps == PWR_STBY) begin
        s.out19 = 1'b0; s.dc19_dis = 1'b1; s.chg = 1'b0; s.dischg = 1'b0;
      end
      if (ps == PWR_ON) begin
        ps = PWR_STBY; s.out19 = 1'b0; s.dc19_dis = 1'b1; s.dischg = 1'b1;
      end
    end

    pwr_next = ps;
    bat_next = bm;
    sw_next  = s;
    pwm_wr   = wr;
    pwm_val  = wr ? pwm_setpoint : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwr_state   <= PWR_STBY;
      bat_mode    <= BAT_INIT;
      sw          <= SW_RST;
      online_prev <= 1'b0;
    end else if (adv) begin
      pwr_state   <= pwr_next;
      bat_mode    <= bat_next;
      sw          <= sw_next;
      online_prev <= online;
    end
  end

  a_charged_sw_off: assert property (@(posedge clk) disable iff (rst)
    bat_mode == BAT_CHARGED |-> !sw.chg)
    else $error("charge switch on while charged");
  a_on_drives_out19: assert property (@(posedge clk) disable iff (rst)
    adv && evt.toggle && (pwr_state == PWR_STBY || pwr_state == PWR_STBY_CHG) && !slow
      |=> pwr_state == PWR_ON && sw.out19)
    else $error("toggle to on did not enable output");

endmodule

@@ rtl/core/ups_power_and_charge_controller_top.sv @@
// Top level of the UPS power and charge controller: handshake, config and stages.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one word per 1 ms tick: button
//    level, input voltage code, charge current, battery capacity, slow tick.
//  - Output channel (out_valid/out_ready) returns exactly one result word per
//    input word: module and charge state, online flag, switch levels, charge
//    PWM strobe and value, and the button hold level.
//  - Config port: cfg_we writes cfg_data into register cfg_index (0 online
//    threshold, 1 low level, 2 empty level, 3 PWM setpoint). Write only
//    while the block is idle.
//  - Timing: an accepted input word passes the input register, then the result
//    register. Throughput: one word per cycle while the output is not stalled, the state
//    update being a single pass of compare/select logic between the two registers.
//  - Stalls: the result register holds while out_ready is low; the input
//    register still takes a word if the result register is empty or
//    draining, so in_ready drops only with both stages full and stalled.
//  - Reset (rst, synchronous): both stages empty, standby power state, init
//    charge state, 19 V output off and converter disabled, discharge on,
//    config registers back to their defaults.
module ups_power_and_charge_controller_top
  import ucc_pkg::*;
#(
  parameter int unsigned HOLD_MAX_TICKS = HOLD_MAX_TICKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  button_level,
  input  logic [9:0]            input_voltage_code,
  input  logic signed [15:0]    charge_current_ma,
  input  logic signed [7:0]     batt_pct,
  input  logic                  slow_tick,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            module_state,
  output logic [2:0]            batt_status,
  output logic                  online_flag,
  output logic                  output19_on,
  output logic                  dc19_disable,
  output logic                  charge_switch,
  output logic                  discharge_switch,
  output logic                  charge_pwm_write,
  output logic [7:0]            charge_pwm_value,
  output logic [2:0]            press_level,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // config registers
  logic [9:0] online_threshold;
  logic [6:0] batt_low_level;
  logic [6:0] batt_empty_level;
  logic [7:0] charge_pwm_setpoint;

  always_ff @(posedge clk) begin
    if (rst) begin
      online_threshold    <= ONLINE_THRESHOLD_RST;
      batt_low_level      <= BATT_LOW_RST;
      batt_empty_level    <= BATT_EMPTY_RST;
      charge_pwm_setpoint <= PWM_SETPOINT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ONLINE_THRESHOLD:    online_threshold    <= cfg_data[9:0];
        REG_BATT_LOW_LEVEL:      batt_low_level      <= cfg_data[6:0];
        REG_BATT_EMPTY_LEVEL:    batt_empty_level    <= cfg_data[6:0];
        REG_CHARGE_PWM_SETPOINT: charge_pwm_setpoint <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input register
  logic               s1_valid;
  logic               s1_btn;
  logic [9:0]         s1_vcode;
  logic signed [15:0] s1_cur;
  logic signed [7:0]  s1_cap;
  logic               s1_slow;
  logic               adv;

  // a word moves into the result register when that register is free or being read
  assign adv      = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_btn   <= button_level;
      s1_vcode <= input_voltage_code;
      s1_cur   <= charge_current_ma;
      s1_cap   <= batt_pct;
      s1_slow  <= slow_tick;
    end
  end

  // per-tick state update
  hold_lvl_t  lvl_next;
  btn_evt_t   evt;
  pwr_state_t pwr_next;
  bat_mode_t  bat_next;
  sw_t        sw_next;
  logic       online;
  logic       pwm_wr;
  logic [7:0] pwm_val;

  ucc_button #(
    .HOLD_MAX_TICKS(HOLD_MAX_TICKS)
  ) u_button (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .held      (s1_btn),
    .level_next(lvl_next),
    .evt       (evt)
  );

  ucc_power u_power (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .evt         (evt),
    .vcode       (s1_vcode),
    .cur_ma      (s1_cur),
    .cap         (s1_cap),
    .slow        (s1_slow),
    .online_thr  (online_threshold),
    .low_lvl     (batt_low_level),
    .empty_lvl   (batt_empty_level),
    .pwm_setpoint(charge_pwm_setpoint),
    .pwr_next    (pwr_next),
    .bat_next    (bat_next),
    .sw_next     (sw_next),
    .online      (online),
    .pwm_wr      (pwm_wr),
    .pwm_val     (pwm_val)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      module_state     <= pwr_next;
      batt_status      <= bat_next;
      online_flag      <= online;
      output19_on      <= sw_next.out19;
      dc19_disable     <= sw_next.dc19_dis;
      charge_switch    <= sw_next.chg;
      discharge_switch <= sw_next.dischg;
      charge_pwm_write <= pwm_wr;
      charge_pwm_value <= pwm_val;
      press_level      <= lvl_next;
    end
  end

  a_stall_keeps_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped during stall");
  a_pwm_value_strobe: assert property (@(posedge clk) disable iff (rst)
    out_valid && charge_pwm_value != 8'd0 |-> charge_pwm_write)
    else $error("PWM value without strobe");
  a_no_adv_when_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !adv)
    else $error("result overwritten during stall");

endmodule
